// File: rtl/cau_pkg.sv
// Shared types, codes and the saturation helper of the complex arithmetic unit.
// Depends on nothing; every other file refers to it by scoped names.
package cau_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  localparam int PART_W = 16;  // width of every real and imaginary part
  localparam int QUOT_W = 16;  // quotient bits built by the divider
  localparam int PROD_W = 32;  // exact 16 x 16 product
  localparam int WIDE_W = 34;  // signed width that holds every value before clipping

  typedef struct packed {
    logic              is_div;
    logic              dz;
    logic              neg_re;
    logic              neg_im;
    logic              ovf_re;
    logic              ovf_im;
    logic [PART_W-1:0] res_re;
    logic [PART_W-1:0] res_im;
    logic              sat;
  } side_t;

  typedef struct packed {
    logic [PART_W-1:0] val;
    logic              sat;
  } clip_t;

  function automatic clip_t clip16(input logic signed [WIDE_W-1:0] v);
    clip_t c;
    if (v > WIDE_W'(signed'(32767))) begin
      c.val = 16'h7fff;
      c.sat = 1'b1;
    end else if (v < -WIDE_W'(signed'(32768))) begin
      c.val = 16'h8000;
      c.sat = 1'b1;
    end else begin
      c.val = v[PART_W-1:0];
      c.sat = 1'b0;
    end
    return c;
  endfunction

endpackage

// File: rtl/cau_div_step.sv
// One registered restoring-division step: tries the divisor at one bit position.
// Depends on cau_pkg for the quotient width.
module cau_div_step #(
  parameter int RW    = 48,
  parameter int SHIFT = 0
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [RW-1:0]              rem_i,
  input  logic [31:0]                d_i,
  input  logic [cau_pkg::QUOT_W-1:0] q_i,
  output logic [RW-1:0]              rem_r,
  output logic [31:0]                d_r,
  output logic [cau_pkg::QUOT_W-1:0] q_r
);

  logic [RW-1:0]              dsh;
  logic [RW:0]                diff;
  logic [RW-1:0]              rem_nxt;
  logic [cau_pkg::QUOT_W-1:0] q_nxt;

  always_comb begin
    dsh     = RW'(d_i) << SHIFT;
    diff    = {1'b0, rem_i} - {1'b0, dsh};
    rem_nxt = diff[RW] ? rem_i : diff[RW-1:0];
    q_nxt   = q_i;
    q_nxt[SHIFT] = ~diff[RW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      d_r   <= d_i;
      q_r   <= q_nxt;
    end
  end

endmodule

// File: rtl/cau_divider.sv
// Pipelined two-lane divider, one quotient bit per stage, with valid and side data.
// Depends on cau_pkg and cau_div_step.
module cau_divider #(
  parameter int RW = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  cau_pkg::side_t             in_side,
  input  logic [RW-1:0]              in_n_re,
  input  logic [RW-1:0]              in_n_im,
  input  logic [31:0]                in_d,
  output logic                       out_valid,
  output cau_pkg::side_t             out_side,
  output logic [cau_pkg::QUOT_W-1:0] out_q_re,
  output logic [cau_pkg::QUOT_W-1:0] out_q_im
);

  localparam int N = cau_pkg::QUOT_W;

  logic [RW-1:0]  rem_re [0:N];
  logic [RW-1:0]  rem_im [0:N];
  logic [31:0]    d_re   [0:N];
  logic [31:0]    d_im   [0:N];
  logic [N-1:0]   q_re   [0:N];
  logic [N-1:0]   q_im   [0:N];
  logic [N:0]     v_r;
  cau_pkg::side_t side_r [0:N];

  assign rem_re[0] = in_n_re;
  assign rem_im[0] = in_n_im;
  assign d_re[0]   = in_d;
  assign d_im[0]   = in_d;
  assign q_re[0]   = '0;
  assign q_im[0]   = '0;
  assign v_r[0]    = in_valid;
  assign side_r[0] = in_side;

  for (genvar k = 0; k < N; k++) begin : g_step
    cau_div_step #(.RW(RW), .SHIFT(N-1-k)) u_re (
      .clk(clk), .en(en), .rem_i(rem_re[k]), .d_i(d_re[k]), .q_i(q_re[k]),
      .rem_r(rem_re[k+1]), .d_r(d_re[k+1]), .q_r(q_re[k+1])
    );
    cau_div_step #(.RW(RW), .SHIFT(N-1-k)) u_im (
      .clk(clk), .en(en), .rem_i(rem_im[k]), .d_i(d_im[k]), .q_i(q_im[k]),
      .rem_r(rem_im[k+1]), .d_r(d_im[k+1]), .q_r(q_im[k+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = v_r[N];
  assign out_side  = side_r[N];
  assign out_q_re  = q_re[N];
  assign out_q_im  = q_im[N];

endmodule

// File: rtl/complex_arithmetic_unit.sv
// Complex ALU (add, subtract, multiply, divide) on signed fixed-point parts.
// Every operation takes the same path: four front stages, 16 divider stages
// (one quotient bit each) and the output register. Throughput is one transfer per
// cycle; a stall on the output freezes the whole pipeline. Synchronous active-low
// reset clears all valid bits; payload registers are not reset.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // a_re, a_im, b_re, b_im
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // r_re, r_im
  output logic [1:0]  out_tuser   // saturated, div_by_zero
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int RW = (NW > 48) ? NW : 48;
  localparam int W  = cau_pkg::WIDE_W;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage 1: operand register.
  logic               v1_r;
  cau_pkg::func_t     func1_r;
  logic signed [15:0] ar1_r, ai1_r, br1_r, bi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func1_r <= cau_pkg::func_t'(in_tuser);
      ar1_r   <= in_tdata[15:0];
      ai1_r   <= in_tdata[31:16];
      br1_r   <= in_tdata[47:32];
      bi1_r   <= in_tdata[63:48];
    end
  end

  // Stage 2: products and the add/subtract sums.
  logic               v2_r;
  cau_pkg::func_t     func2_r;
  logic signed [31:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_br_r, p_bi_r;
  logic signed [16:0] s_re_r, s_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func2_r <= func1_r;
      p_rr_r  <= ar1_r * br1_r;
      p_ii_r  <= ai1_r * bi1_r;
      p_ri_r  <= ar1_r * bi1_r;
      p_ir_r  <= ai1_r * br1_r;
      p_br_r  <= br1_r * br1_r;
      p_bi_r  <= bi1_r * bi1_r;
      if (func1_r == cau_pkg::FUNC_SUB) begin
        s_re_r <= {ar1_r[15], ar1_r} - {br1_r[15], br1_r};
        s_im_r <= {ai1_r[15], ai1_r} - {bi1_r[15], bi1_r};
      end else begin
        s_re_r <= {ar1_r[15], ar1_r} + {br1_r[15], br1_r};
        s_im_r <= {ai1_r[15], ai1_r} + {bi1_r[15], bi1_r};
      end
    end
  end

  // Stage 3: sums of products, magnitudes, and the final result of the easy operations.
  logic signed [32:0] m_re, m_im, n_re, n_im;
  logic [32:0]        mm_re, mm_im, nm_re, nm_im;
  logic signed [W-1:0] w_re, w_im;
  cau_pkg::clip_t     c_re, c_im;
  cau_pkg::side_t     side3_nxt;

  always_comb begin
    m_re  = {p_rr_r[31], p_rr_r} - {p_ii_r[31], p_ii_r};
    m_im  = {p_ri_r[31], p_ri_r} + {p_ir_r[31], p_ir_r};
    n_re  = {p_rr_r[31], p_rr_r} + {p_ii_r[31], p_ii_r};
    n_im  = {p_ir_r[31], p_ir_r} - {p_ri_r[31], p_ri_r};
    mm_re = m_re[32] ? 33'(-m_re) : 33'(m_re);
    mm_im = m_im[32] ? 33'(-m_im) : 33'(m_im);
    nm_re = n_re[32] ? 33'(-n_re) : 33'(n_re);
    nm_im = n_im[32] ? 33'(-n_im) : 33'(n_im);
    if (func2_r == cau_pkg::FUNC_MUL) begin
      w_re = m_re[32] ? -W'(mm_re >> FRAC_BITS) : W'(mm_re >> FRAC_BITS);
      w_im = m_im[32] ? -W'(mm_im >> FRAC_BITS) : W'(mm_im >> FRAC_BITS);
    end else begin
      w_re = W'(s_re_r);
      w_im = W'(s_im_r);
    end
    c_re = cau_pkg::clip16(w_re);
    c_im = cau_pkg::clip16(w_im);
    side3_nxt.is_div = (func2_r == cau_pkg::FUNC_DIV);
    side3_nxt.dz     = 1'b0;
    side3_nxt.neg_re = n_re[32];
    side3_nxt.neg_im = n_im[32];
    side3_nxt.ovf_re = 1'b0;
    side3_nxt.ovf_im = 1'b0;
    side3_nxt.res_re = c_re.val;
    side3_nxt.res_im = c_im.val;
    side3_nxt.sat    = c_re.sat | c_im.sat;
  end

  logic           v3_r;
  cau_pkg::side_t side3_r;
  logic [31:0]    nm_re3_r, nm_im3_r, den3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r  <= side3_nxt;
      nm_re3_r <= nm_re[31:0];
      nm_im3_r <= nm_im[31:0];
      den3_r   <= 32'(p_br_r) + 32'(p_bi_r);
    end
  end

  // Stage 4: scaled numerators, the zero-divisor check and the check for a quotient beyond 16 bits.
  logic [RW-1:0]  big_n_re, big_n_im, d_top;
  cau_pkg::side_t side4_nxt;

  always_comb begin
    big_n_re  = RW'(nm_re3_r) << FRAC_BITS;
    big_n_im  = RW'(nm_im3_r) << FRAC_BITS;
    d_top     = RW'(den3_r) << cau_pkg::QUOT_W;
    side4_nxt = side3_r;
    side4_nxt.ovf_re = (big_n_re >= d_top);
    side4_nxt.ovf_im = (big_n_im >= d_top);
    side4_nxt.dz     = side3_r.is_div && (den3_r == '0);
  end

  logic           v4_r;
  cau_pkg::side_t side4_r;
  logic [RW-1:0]  n_re4_r, n_im4_r;
  logic [31:0]    den4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r <= side4_nxt;
      n_re4_r <= big_n_re;
      n_im4_r <= big_n_im;
      den4_r  <= den3_r;
    end
  end

  logic                       vd;
  cau_pkg::side_t             sided;
  logic [cau_pkg::QUOT_W-1:0] q_re, q_im;

  cau_divider #(.RW(RW)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v4_r), .in_side(side4_r),
    .in_n_re(n_re4_r), .in_n_im(n_im4_r), .in_d(den4_r),
    .out_valid(vd), .out_side(sided), .out_q_re(q_re), .out_q_im(q_im)
  );

  // Output stage: sign and clip the quotients, then pick the result.
  logic [15:0] r_re_nxt, r_im_nxt;
  logic        sat_nxt, dz_nxt, sat_re, sat_im;
  logic [15:0] dq_re, dq_im;

  always_comb begin
    sat_re = sided.ovf_re || (sided.neg_re ? (q_re > 16'h8000) : q_re[15]);
    sat_im = sided.ovf_im || (sided.neg_im ? (q_im > 16'h8000) : q_im[15]);
    if (sat_re) begin
      dq_re = sided.neg_re ? 16'h8000 : 16'h7fff;
    end else begin
      dq_re = sided.neg_re ? 16'(-q_re) : q_re;
    end
    if (sat_im) begin
      dq_im = sided.neg_im ? 16'h8000 : 16'h7fff;
    end else begin
      dq_im = sided.neg_im ? 16'(-q_im) : q_im;
    end
    dz_nxt = sided.dz;
    if (!sided.is_div) begin
      r_re_nxt = sided.res_re;
      r_im_nxt = sided.res_im;
      sat_nxt  = sided.sat;
    end else if (sided.dz) begin
      r_re_nxt = '0;
      r_im_nxt = '0;
      sat_nxt  = 1'b0;
    end else begin
      r_re_nxt = dq_re;
      r_im_nxt = dq_im;
      sat_nxt  = sat_re | sat_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= {r_im_nxt, r_re_nxt};
      out_tuser <= {dz_nxt, sat_nxt};
    end
  end

  // A zero divisor gives a clean zero result.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> (out_tdata == '0) && !out_tuser[0])
    else $error("divide by zero result not zero");

  // A clipped result has at least one part at a range limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata[15:0] == 16'h7fff) || (out_tdata[15:0] == 16'h8000) ||
      (out_tdata[31:16] == 16'h7fff) || (out_tdata[31:16] == 16'h8000))
    else $error("saturation flag without a clipped part");

  // While the output stalls, the front stages hold.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v1_r) && $stable(v4_r))
    else $error("pipeline moved during a stall");

endmodule
